>>> rtl/pcr_pkg.sv
// ----------------------------------------------------------------------------
// pcr_pkg
// Shared types and constants for the prime counter: field widths, the
// saturating count type and the status bundles passed between units.
// ----------------------------------------------------------------------------
package pcr_pkg;

    // Widths of the request and result fields
    localparam int unsigned FIELD_W = 16;
    localparam int unsigned COUNT_W = 13;

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Count saturates at the top of its field
    localparam count_t COUNT_MAX = '1;

    // Status from the bit-serial remainder unit
    typedef struct packed {
        logic done;   // one-cycle pulse, remainder is final
        logic zero;   // remainder equals zero
    } rem_status_t;

    // Status from the primality tester
    typedef struct packed {
        logic done;   // one-cycle pulse, verdict is valid
        logic prime;  // candidate is prime
    } prime_status_t;

endpackage

>>> rtl/pcr_if.sv
// ----------------------------------------------------------------------------
// pcr_req_if / pcr_rsp_if
// Valid/ready channels for range requests and prime count results.
// ----------------------------------------------------------------------------
interface pcr_req_if;
    logic              valid;
    logic              ready;
    pcr_pkg::field_t   range_low;
    pcr_pkg::field_t   range_high;

    modport source (output valid, output range_low, output range_high, input ready);
    modport sink   (input valid, input range_low, input range_high, output ready);
endinterface

interface pcr_rsp_if;
    logic              valid;
    logic              ready;
    pcr_pkg::count_t   prime_count;

    modport source (output valid, output prime_count, input ready);
    modport sink   (input valid, input prime_count, output ready);
endinterface

>>> rtl/prime_count_in_range.sv
// ----------------------------------------------------------------------------
// prime_count_in_range
// Counts the primes in an inclusive range [range_low, range_high].
// ----------------------------------------------------------------------------
// One request is handled at a time. Every value of the range is tested by
// trial division with a bit-serial remainder unit, one divisor at a time; a
// prime value n needs about sqrt(n)/2 divisions, a value with a small factor
// far fewer, and even or tiny values none. Bounds are taken modulo
// 2^VALUE_WIDTH, an empty range gives 0, and the count saturates at 8191.
// The result is held on the response channel until it is taken; a new
// request is accepted once it has been transferred.
// ----------------------------------------------------------------------------
module prime_count_in_range #(
    parameter int unsigned VALUE_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    pcr_req_if.sink      req,
    pcr_rsp_if.source    rsp
);
    import pcr_pkg::*;

    localparam int unsigned VW   = VALUE_WIDTH;
    localparam int unsigned IN_W = (VW < FIELD_W) ? VW : FIELD_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_TEST = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t        state_reg, state_next;
    logic [VW-1:0] n_reg, n_next;
    logic [VW-1:0] hi_reg, hi_next;
    count_t        count_reg, count_next;
    logic [VW-1:0] lo_in, hi_in;
    logic          test_start;
    prime_status_t test_st;

    // Bounds reduced to the value width
    assign lo_in = VW'(req.range_low[IN_W-1:0]);
    assign hi_in = VW'(req.range_high[IN_W-1:0]);

    pcr_prime #(.W(VW)) u_prime (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (test_start),
        .cand   (n_reg),
        .status (test_st)
    );

    // Range scan
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        hi_next    = hi_reg;
        count_next = count_reg;
        test_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    n_next     = lo_in;
                    hi_next    = hi_in;
                    count_next = '0;
                    if (lo_in > hi_in)
                        state_next = S_OUT;
                    else
                        state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                test_start = 1'b1;
                state_next = S_TEST;
            end
            S_TEST:
            begin
                if (test_st.done)
                begin
                    if (test_st.prime && (count_reg != COUNT_MAX))
                        count_next = count_reg + COUNT_W'(1);
                    // Stop at the top bound, no wrap past the largest value
                    if (n_reg == hi_reg)
                        state_next = S_OUT;
                    else
                    begin
                        n_next     = n_reg + VW'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            S_OUT:
            begin
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        hi_reg    <= hi_next;
        count_reg <= count_next;
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = (state_reg == S_OUT);
    assign rsp.prime_count = count_reg;

endmodule

>>> rtl/pcr_rem.sv
// ----------------------------------------------------------------------------
// pcr_rem
// Bit-serial restoring remainder: shifts the dividend in MSB first, one bit
// per cycle, and reports whether the final remainder is zero.
// ----------------------------------------------------------------------------
module pcr_rem #(
    parameter int unsigned W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [W-1:0]         dividend,
    input  logic [W-1:0]         divisor,
    output pcr_pkg::rem_status_t status
);
    import pcr_pkg::*;

    localparam int unsigned CW = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  dvd_reg, dvd_next;
    logic [W-1:0]  dsr_reg, dsr_next;
    logic [W-1:0]  rem_reg, rem_next;
    logic [W:0]    trial;
    logic [W:0]    diff;

    // One restoring step per cycle
    always_comb
    begin
        trial     = {rem_reg, dvd_reg[W-1]};
        diff      = trial - {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
                rem_next = diff[W-1:0];
            else
                rem_next = trial[W-1:0];
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

>>> rtl/pcr_prime.sv
// ----------------------------------------------------------------------------
// pcr_prime
// Primality tester: screens small and even values, then tries odd
// divisors 3, 5, 7 ... while the divisor squared stays within the candidate.
// ----------------------------------------------------------------------------
module pcr_prime #(
    parameter int unsigned W = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [W-1:0]           cand,
    output pcr_pkg::prime_status_t status
);
    import pcr_pkg::*;

    typedef enum logic [2:0] {
        P_IDLE  = 3'b001,
        P_CHECK = 3'b010,
        P_DIV   = 3'b100
    } pstate_t;

    pstate_t      state_reg, state_next;
    logic         done_reg, done_next;
    logic         prime_reg, prime_next;
    logic [W-1:0] n_reg, n_next;
    logic [W-1:0] d_reg, d_next;
    logic [W+1:0] sq_reg, sq_next;
    logic         rem_start;
    rem_status_t  rem_st;

    pcr_rem #(.W(W)) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .status   (rem_st)
    );

    // Divisor sequencer
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        prime_next = prime_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        rem_start  = 1'b0;
        case (state_reg)
            P_IDLE:
            begin
                if (start)
                begin
                    n_next = cand;
                    if (cand < W'(2))
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                    end
                    else if (cand < W'(4))
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b1;
                    end
                    else if (!cand[0])
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                    end
                    else
                    begin
                        d_next     = W'(3);
                        sq_next    = (W+2)'(9);
                        state_next = P_CHECK;
                    end
                end
            end
            P_CHECK:
            begin
                // Divisor squared past the candidate: no factor left
                if (sq_reg > {2'b00, n_reg})
                begin
                    done_next  = 1'b1;
                    prime_next = 1'b1;
                    state_next = P_IDLE;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = P_DIV;
                end
            end
            P_DIV:
            begin
                if (rem_st.done)
                begin
                    if (rem_st.zero)
                    begin
                        done_next  = 1'b1;
                        prime_next = 1'b0;
                        state_next = P_IDLE;
                    end
                    else
                    begin
                        // (d+2)^2 = d^2 + 4d + 4
                        d_next     = d_reg + W'(2);
                        sq_next    = sq_reg + {d_reg, 2'b00} + (W+2)'(4);
                        state_next = P_CHECK;
                    end
                end
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        prime_reg <= prime_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
    end

    assign status.done  = done_reg;
    assign status.prime = prime_reg;

endmodule

>>> rtl/pcr_checker.sv
// ----------------------------------------------------------------------------
// pcr_checker
// Port-level checks for the prime counter, bound to the top level.
// ----------------------------------------------------------------------------
module pcr_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input pcr_pkg::count_t   prime_count
);
    import pcr_pkg::*;

    // A pending result stays offered until transferred
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result withdrawn before transfer");

    // A pending result keeps its value
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(prime_count))
        else $error("result changed while stalled");

    // One request at a time: no new request while a result is offered
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_ready && rsp_valid))
        else $error("request accepted while result pending");

    // After a request transfer the block is busy
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("ready stayed high after request transfer");

    // A result is given once
    a_single_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |=> !rsp_valid)
        else $error("result repeated after transfer");

endmodule

bind prime_count_in_range pcr_checker u_pcr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .prime_count (rsp.prime_count)
);
